// ===== rtl/four_function_calculator_core_macros.svh =====
// Assertion helpers shared by the calculator RTL.
// Each macro checks one property on the rising clock edge, disabled in reset.
`ifndef FOUR_FUNCTION_CALCULATOR_CORE_MACROS_SVH
`define FOUR_FUNCTION_CALCULATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define FFC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calculator check failed in the same cycle");

`define FFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calculator check failed one cycle later");

`else

`define FFC_ASSERT_SAME(label, clk, rst, ante, cons)

`define FFC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ffc_pkg.sv =====
`default_nettype none

package ffc_pkg;

   localparam int MAX_DIGITS = 31;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int DATA_W     = 64;
   localparam int ITER_W     = $clog2(DATA_W);
   localparam int DIGIT_W    = 4;
   localparam int MODE_W     = 3;
   localparam int KEY_W      = 4;
   localparam int OPN_W      = 3;
   localparam int LEN_W      = 5;

   localparam logic [KEY_W-1:0] KEY_MAX_DIGIT = KEY_W'(9);
   localparam logic [KEY_W-1:0] KEY_MAX_OPER  = KEY_W'(3);

   typedef enum logic [MODE_W-1:0] {
      MODE_DIGIT  = 3'd0,
      MODE_OPER   = 3'd1,
      MODE_EQUALS = 3'd2,
      MODE_CLEAR  = 3'd3,
      MODE_BACK   = 3'd4
   } mode_type;

   typedef enum logic [OPN_W-1:0] {
      OP_NONE = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   typedef struct packed {
      logic start;
      logic is_div;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

   // Operator keys 0..3 map onto the stored operation codes add..divide.
   function automatic op_type op_from_key(input logic [KEY_W-1:0] key);
      op_type op;
      case (key[1:0])
         2'd0:    op = OP_ADD;
         2'd1:    op = OP_SUB;
         2'd2:    op = OP_MUL;
         2'd3:    op = OP_DIV;
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ffc_if.sv =====
`default_nettype none

interface ffc_req_if;
   import ffc_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [KEY_W-1:0]  key_value;

   modport source (output valid, output mode, output key_value, input ready);
   modport sink   (input valid, input mode, input key_value, output ready);
endinterface

interface ffc_rsp_if;
   import ffc_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] accumulator;
   logic [LEN_W-1:0]  entry_length;
   logic              operation_pending;
   logic [OPN_W-1:0]  pending_operation;
   logic              digit_dropped;

   modport source (output valid, output accumulator, output entry_length,
                   output operation_pending, output pending_operation,
                   output digit_dropped, input ready);
   modport sink   (input valid, input accumulator, input entry_length,
                   input operation_pending, input pending_operation,
                   input digit_dropped, output ready);
endinterface

`default_nettype wire

// ===== rtl/ffc_digit_store.sv =====
`default_nettype none

module ffc_digit_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ffc_pkg::IDX_W-1:0]   wr_addr,
   input  logic [ffc_pkg::DIGIT_W-1:0] wr_data,
   input  logic [ffc_pkg::IDX_W-1:0]   rd_addr,
   output logic [ffc_pkg::DIGIT_W-1:0] rd_data
);
   import ffc_pkg::*;

   logic [DIGIT_W-1:0] mem [MAX_DIGITS];
   logic [DIGIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ffc_arith.sv =====
`default_nettype none

// Iterative multiply / divide on one shared adder, one bit per cycle.
module ffc_arith (
   input  logic                       clock,
   input  logic                       reset,
   input  ffc_pkg::arith_cmd_type     cmd,
   input  logic [ffc_pkg::DATA_W-1:0] opa,
   input  logic [ffc_pkg::DATA_W-1:0] opb,
   output ffc_pkg::arith_stat_type    stat,
   output logic [ffc_pkg::DATA_W-1:0] result
);
   import ffc_pkg::*;

   localparam int ADD_W = DATA_W + 2;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              is_div_ff, is_div_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DATA_W-1:0] a_ff, a_in;   // multiplicand, or dividend shifting into quotient
   logic [DATA_W-1:0] b_ff, b_in;   // multiplier, or divisor
   logic [DATA_W-1:0] r_ff, r_in;   // product, or partial remainder

   logic [DATA_W:0]   rem_sh;
   logic [ADD_W-1:0]  add_x;
   logic [ADD_W-1:0]  add_y;
   logic [ADD_W-1:0]  sum;
   logic              carry;

   // The single adder: product plus multiplicand, or shifted remainder minus divisor.
   // In divide mode the top bit of the sum is set when the remainder covers the divisor.
   always_comb begin
      rem_sh = {r_ff, a_ff[DATA_W-1]};
      if (is_div_ff) begin
         add_x = {1'b0, rem_sh};
         add_y = {1'b0, ~{1'b0, b_ff}};
      end else begin
         add_x = {2'b00, r_ff};
         add_y = {2'b00, a_ff};
      end
      sum   = add_x + add_y + ADD_W'(is_div_ff);
      carry = sum[ADD_W-1];
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      is_div_in = is_div_ff;
      iter_in   = iter_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      r_in      = r_ff;
      if (cmd.start && !busy_ff) begin
         busy_in   = 1'b1;
         is_div_in = cmd.is_div;
         iter_in   = '0;
         a_in      = opa;
         b_in      = opb;
         r_in      = '0;
      end else if (busy_ff) begin
         if (is_div_ff) begin
            r_in = carry ? sum[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            a_in = {a_ff[DATA_W-2:0], carry};
         end else begin
            if (b_ff[0]) begin
               r_in = sum[DATA_W-1:0];
            end
            a_in = {a_ff[DATA_W-2:0], 1'b0};
            b_in = {1'b0, b_ff[DATA_W-1:1]};
         end
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      iter_ff   <= iter_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      r_ff      <= r_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = is_div_ff ? a_ff : r_ff;

endmodule

`default_nettype wire

// ===== rtl/four_function_calculator_core.sv =====
// Digit, clear and backspace words go from IDLE straight to DONE and the output register.
// Operator and equals first walk each entry digit through FETCH and ACC, reading the
// registered digit store, then wait in WAIT when a multiply or divide runs.
// The block handles one word at a time and takes no new word until the last one is done.
// Reset is synchronous and active high; it clears the accumulator, entry and operation.
// The digit store has no reset and needs no clearing pass.
`default_nettype none

`include "four_function_calculator_core_macros.svh"

module four_function_calculator_core (
   input  logic      clock,
   input  logic      reset,
   ffc_req_if.sink   req_chan,
   ffc_rsp_if.source rsp_chan
);
   import ffc_pkg::*;

   // Sequencer states. A word enters only in IDLE. Operator and equals walk the
   // entry digits through FETCH and ACC, combine in APPLY, and wait in WAIT while
   // the shared multiply/divide unit iterates. DONE hands the result to the output
   // register as soon as that register is free.
   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_ACC,
      S_APPLY,
      S_WAIT,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;
   op_type            op_ff, op_in;
   logic              is_oper_ff, is_oper_in;
   op_type            new_op_ff, new_op_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              drop_ff, drop_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_acc_ff, rsp_acc_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic              rsp_pend_ff, rsp_pend_in;
   op_type            rsp_op_ff, rsp_op_in;
   logic              rsp_drop_ff, rsp_drop_in;

   logic               wr_en;
   logic [DIGIT_W-1:0] rd_data;
   logic               finish;
   logic               start_eval;
   logic               clear_all;
   logic               req_take;
   logic               rsp_load;
   arith_cmd_type      arith_cmd;
   arith_stat_type     arith_stat;
   logic [DATA_W-1:0]  arith_res;

   // Entry digits live in a small memory with a registered read port.
   ffc_digit_store u_digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_chan.key_value[DIGIT_W-1:0]),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   // Multiply and divide share one iterative unit that retires one bit per cycle.
   ffc_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .opa    (acc_ff),
      .opb    (val_ff),
      .stat   (arith_stat),
      .result (arith_res)
   );

   assign req_chan.ready = (state_ff == S_IDLE);

   // A key word is taken this cycle, and a finished word moves to the output register.
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      is_oper_in   = is_oper_ff;
      new_op_in    = new_op_ff;
      rd_idx_in    = rd_idx_ff;
      val_in       = val_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_op_in    = rsp_op_ff;
      rsp_drop_in  = rsp_drop_ff;
      wr_en        = 1'b0;
      finish       = 1'b0;
      start_eval   = 1'b0;
      clear_all    = 1'b0;
      arith_cmd    = '0;

      // The output register frees up when its word is taken.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               drop_in  = 1'b0;
               state_in = S_DONE;
               case (req_chan.mode)
                  MODE_DIGIT: begin
                     // Digits above nine are ignored; a full entry drops the digit.
                     if (req_chan.key_value <= KEY_MAX_DIGIT) begin
                        if (count_ff < CNT_W'(MAX_DIGITS)) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CNT_W'(1);
                        end else begin
                           drop_in = 1'b1;
                        end
                     end
                  end
                  MODE_OPER: begin
                     if (req_chan.key_value <= KEY_MAX_OPER) begin
                        is_oper_in = 1'b1;
                        new_op_in  = op_from_key(req_chan.key_value);
                        start_eval = 1'b1;
                     end
                  end
                  MODE_EQUALS: begin
                     is_oper_in = 1'b0;
                     start_eval = 1'b1;
                  end
                  MODE_CLEAR: begin
                     clear_all = 1'b1;
                  end
                  MODE_BACK: begin
                     // Backspace on an empty entry clears everything.
                     if (count_ff != '0) begin
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        clear_all = 1'b1;
                     end
                  end
                  default: begin
                     // Unused key kinds leave the state as it is.
                  end
               endcase
            end
         end
         S_FETCH: begin
            // The digit at rd_idx_ff is read into the store's output register.
            state_in = S_ACC;
         end
         S_ACC: begin
            // value = value * 10 + digit, wrapping modulo 2^64.
            val_in = (val_ff << 3) + (val_ff << 1) + DATA_W'(rd_data);
            if (CNT_W'(rd_idx_ff) + CNT_W'(1) == count_ff) begin
               state_in = S_APPLY;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
               state_in  = S_FETCH;
            end
         end
         S_APPLY: begin
            if (!pend_ff) begin
               acc_in = val_ff;
               finish = 1'b1;
            end else begin
               case (op_ff)
                  OP_ADD: begin
                     acc_in = acc_ff + val_ff;
                     finish = 1'b1;
                  end
                  OP_SUB: begin
                     // Subtraction saturates at zero.
                     acc_in = (acc_ff > val_ff) ? (acc_ff - val_ff) : '0;
                     finish = 1'b1;
                  end
                  OP_MUL: begin
                     arith_cmd.start  = 1'b1;
                     arith_cmd.is_div = 1'b0;
                     state_in         = S_WAIT;
                  end
                  OP_DIV: begin
                     // Division by zero leaves the accumulator as it is.
                     if (val_ff != '0) begin
                        arith_cmd.start  = 1'b1;
                        arith_cmd.is_div = 1'b1;
                        state_in         = S_WAIT;
                     end else begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_WAIT: begin
            if (arith_stat.done) begin
               acc_in = arith_res;
               finish = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_len_in   = LEN_W'(count_ff);
               rsp_pend_in  = pend_ff;
               rsp_op_in    = op_ff;
               rsp_drop_in  = drop_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // An empty entry evaluates as zero and goes straight to the combine step.
      if (start_eval) begin
         val_in    = '0;
         rd_idx_in = '0;
         state_in  = (count_ff == '0) ? S_APPLY : S_FETCH;
      end

      if (clear_all) begin
         count_in = '0;
         acc_in   = '0;
         pend_in  = 1'b0;
         op_in    = OP_NONE;
      end

      // Operator or equals completes: the entry empties, and an operator becomes
      // the pending operation while equals only drops the pending mark.
      if (finish) begin
         count_in = '0;
         pend_in  = is_oper_ff;
         if (is_oper_ff) begin
            op_in = new_op_ff;
         end
         state_in = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         acc_ff       <= '0;
         pend_ff      <= 1'b0;
         op_ff        <= OP_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_oper_ff  <= is_oper_in;
      new_op_ff   <= new_op_in;
      rd_idx_ff   <= rd_idx_in;
      val_ff      <= val_in;
      drop_ff     <= drop_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_op_ff   <= rsp_op_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.accumulator       = rsp_acc_ff;
   assign rsp_chan.entry_length      = rsp_len_ff;
   assign rsp_chan.operation_pending = rsp_pend_ff;
   assign rsp_chan.pending_operation = rsp_op_ff;
   assign rsp_chan.digit_dropped     = rsp_drop_ff;

   // The block has left IDLE in the cycle after it takes a word.
   `FFC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, state_ff != S_IDLE)
   // The entry never grows past its capacity.
   `FFC_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_DIGITS))
   // The shared unit only reports completion while the sequencer waits for it.
   `FFC_ASSERT_SAME(a_done_while_waiting, clock, reset, arith_stat.done, state_ff == S_WAIT)
   // Only written digit positions are read back during evaluation.
   `FFC_ASSERT_SAME(a_read_below_count, clock, reset, state_ff == S_ACC, CNT_W'(rd_idx_ff) < count_ff)
   // A finished word reaches the output register when it has room.
   `FFC_ASSERT_NEXT(a_result_loaded, clock, reset, rsp_load, rsp_valid_ff && (state_ff == S_IDLE))

endmodule

`default_nettype wire
